// ===== src/lmss_pkg.sv =====
package lmss_pkg;

  // sizes of the display, defaults for the top level
  localparam int VISIBLE_COLS_DEF = 32;
  localparam int BUFFER_COLS_DEF  = 128;
  localparam int NUM_ROWS         = 8;

  // font and row select framing
  localparam int GLYPH_WIDTH = 6;
  localparam int GLYPH_BITS  = GLYPH_WIDTH * 8;
  localparam int SELECT_BITS = 8;
  localparam int ROW_W       = 3;

  // register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIMER_W    = 16;
  localparam int LEN_W      = 8;

  localparam logic [TIMER_W-1:0] SCAN_PERIOD_RST   = 16'd2;
  localparam logic [TIMER_W-1:0] SCROLL_PERIOD_RST = 16'd100;
  localparam logic [LEN_W-1:0]   SCROLL_LENGTH_RST = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_PERIOD   = 2'd0,
    CFG_SCROLL_PERIOD = 2'd1,
    CFG_SCROLL_LENGTH = 2'd2
  } cfg_reg_e;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       first_of_message;
  } cmd_in_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_strobe;
  } res_out_t;

  // framebuffer port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } fb_ctrl_t;

  // 5x7 font, first column in the top byte, blank outside codes 32 to 125
  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [7:0] code);
    logic [GLYPH_BITS-1:0] g;
    case (code)
      8'd32:  g = 48'h000000000000;
      8'd33:  g = 48'h00005F000000;
      8'd34:  g = 48'h000700070000;
      8'd35:  g = 48'h147F147F1400;
      8'd36:  g = 48'h242A7F2A1200;
      8'd37:  g = 48'h231308646200;
      8'd38:  g = 48'h364955225000;
      8'd39:  g = 48'h000503000000;
      8'd40:  g = 48'h001C22410000;
      8'd41:  g = 48'h0041221C0000;
      8'd42:  g = 48'h14083E081400;
      8'd43:  g = 48'h08083E080800;
      8'd44:  g = 48'h005030000000;
      8'd45:  g = 48'h080808080800;
      8'd46:  g = 48'h006060000000;
      8'd47:  g = 48'h201008040200;
      8'd48:  g = 48'h3E4141413E00;
      8'd49:  g = 48'h00427F400000;
      8'd50:  g = 48'h426151494600;
      8'd51:  g = 48'h2141454B3100;
      8'd52:  g = 48'h1814127F1000;
      8'd53:  g = 48'h274545453900;
      8'd54:  g = 48'h3C4A49493000;
      8'd55:  g = 48'h017109050300;
      8'd56:  g = 48'h364949493600;
      8'd57:  g = 48'h064949291E00;
      8'd58:  g = 48'h003636000000;
      8'd59:  g = 48'h005636000000;
      8'd60:  g = 48'h081422410000;
      8'd61:  g = 48'h141414141400;
      8'd62:  g = 48'h004122140800;
      8'd63:  g = 48'h020151090600;
      8'd64:  g = 48'h324979413E00;
      8'd65:  g = 48'h7E0909097E00;
      8'd66:  g = 48'h7F4949493600;
      8'd67:  g = 48'h3E4141412200;
      8'd68:  g = 48'h7F4141221C00;
      8'd69:  g = 48'h7F4949494100;
      8'd70:  g = 48'h7F0909090100;
      8'd71:  g = 48'h3E4149497A00;
      8'd72:  g = 48'h7F0808087F00;
      8'd73:  g = 48'h41417F414100;
      8'd74:  g = 48'h204040403F00;
      8'd75:  g = 48'h7F0814224100;
      8'd76:  g = 48'h7F4040404000;
      8'd77:  g = 48'h7F020C027F00;
      8'd78:  g = 48'h7F0408107F00;
      8'd79:  g = 48'h3E4141413E00;
      8'd80:  g = 48'h7F0909090600;
      8'd81:  g = 48'h3E4151215E00;
      8'd82:  g = 48'h7F0919294600;
      8'd83:  g = 48'h464949493100;
      8'd84:  g = 48'h01017F010100;
      8'd85:  g = 48'h3F4040403F00;
      8'd86:  g = 48'h1F2040201F00;
      8'd87:  g = 48'h3F4038403F00;
      8'd88:  g = 48'h631408146300;
      8'd89:  g = 48'h070870080700;
      8'd90:  g = 48'h615149454300;
      8'd91:  g = 48'h007F41410000;
      8'd92:  g = 48'h020408102000;
      8'd93:  g = 48'h0041417F0000;
      8'd94:  g = 48'h040201020400;
      8'd95:  g = 48'h404040404000;
      8'd96:  g = 48'h000102040000;
      8'd97:  g = 48'h205454547800;
      8'd98:  g = 48'h7F4844443800;
      8'd99:  g = 48'h384444440000;
      8'd100: g = 48'h384444447F00;
      8'd101: g = 48'h385454541800;
      8'd102: g = 48'h087E09010200;
      8'd103: g = 48'h081454543C00;
      8'd104: g = 48'h7F0804047800;
      8'd105: g = 48'h00447D400000;
      8'd106: g = 48'h2040443D0000;
      8'd107: g = 48'h007F10284400;
      8'd108: g = 48'h00417F400000;
      8'd109: g = 48'h7C0418047800;
      8'd110: g = 48'h7C0804047800;
      8'd111: g = 48'h384444443800;
      8'd112: g = 48'h7C1414140800;
      8'd113: g = 48'h081414187C00;
      8'd114: g = 48'h7C0804040800;
      8'd115: g = 48'h485454542000;
      8'd116: g = 48'h043F44402000;
      8'd117: g = 48'h3C4040207C00;
      8'd118: g = 48'h1C2040201C00;
      8'd119: g = 48'h3C4030403C00;
      8'd120: g = 48'h442810284400;
      8'd121: g = 48'h0C5050503C00;
      8'd122: g = 48'h4464544C4400;
      8'd123: g = 48'h000836410000;
      8'd124: g = 48'h00007F000000;
      8'd125: g = 48'h004136080000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== src/lmss_fbuf.sv =====
module lmss_fbuf import lmss_pkg::*; #(
  parameter int DEPTH = BUFFER_COLS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fb_ctrl_t                 ctrl_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [7:0]               wr_data_i,
  output logic [7:0]               rd_data_o
);

  logic [7:0]       fb_mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [7:0]       rd_data_q;
  logic             rd_valid_q;

  // per-column valid bits stand in for clearing the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      fb_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= fb_mem_q[rd_addr_i];
    end
  end

  // never written columns read as blank
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== src/led_matrix_scan_scroll_top.sv =====
// channel  | direction | payload     | accepted when
// cfg      | in        | index, data | cfg_valid_i & cfg_ready_o
// in       | in        | cmd_in_t    | in_valid_i & in_ready_o
// out      | out       | res_out_t   | out_valid_o & out_ready_i
//
// character request: accepted, then the GLYPH_WIDTH glyph columns are written in S_CHAR
// tick request: with a row scan VISIBLE_COLS + 8 result bits follow, one bit per cycle
//   when out is not stalled; column bits come from the single framebuffer read port
// scroll: min(scroll_length, BUFFER_COLS) columns rotate left, one column per cycle
// reset sets control registers and clears framebuffer valid bits at once; no clearing pass
// a stalled result holds the sequencer; the last bit can wait while a new request enters
module led_matrix_scan_scroll_top import lmss_pkg::*; #(
  parameter int VISIBLE_COLS = VISIBLE_COLS_DEF,
  parameter int BUFFER_COLS  = BUFFER_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cmd_in_t               in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output res_out_t              out_res_o
);

  localparam int AW = $clog2(BUFFER_COLS);
  localparam int PW = $clog2(BUFFER_COLS + 1);
  localparam int CW = (VISIBLE_COLS > 1) ? $clog2(VISIBLE_COLS) : 1;
  localparam int SW = $clog2(SELECT_BITS);
  localparam int GW = $clog2(GLYPH_WIDTH);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHAR      = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_SEL       = 3'd3;
  localparam logic [2:0] S_ROT_HEAD  = 3'd4;
  localparam logic [2:0] S_ROT_FIRST = 3'd5;
  localparam logic [2:0] S_ROT_MOVE  = 3'd6;
  localparam logic [2:0] S_ROT_LAST  = 3'd7;

  logic [2:0]            state_q, state_d;
  logic [TIMER_W-1:0]    scan_period_q, scroll_period_q;
  logic [LEN_W-1:0]      scroll_length_q;
  logic [TIMER_W-1:0]    scan_timer_q, scan_timer_d;
  logic [TIMER_W-1:0]    scroll_timer_q, scroll_timer_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [PW-1:0]         wp_q, wp_d;
  logic [CW-1:0]         col_q, col_d;
  logic [SW-1:0]         sel_q, sel_d;
  logic [GW-1:0]         gcnt_q, gcnt_d;
  logic                  rot_pend_q, rot_pend_d;
  logic [AW-1:0]         rot_idx_q, rot_idx_d;
  logic                  scan_oob_q, scan_oob_d;
  logic                  out_valid_q, out_valid_d;
  logic [GLYPH_BITS-1:0] glyph_q, glyph_d;
  logic [7:0]            first_q, first_d;
  res_out_t              out_res_q, out_res_d;

  logic                  in_acc, out_free;
  logic [TIMER_W-1:0]    scan_inc, scroll_inc;
  logic                  scan_exp, scroll_exp;
  logic [ROW_W-1:0]      row_next;
  logic [PW-1:0]         len_eff;
  logic                  rot_ok;
  logic [PW-1:0]         rot_next2;
  logic                  scan_rd;
  logic [CW-1:0]         col_rd;

  fb_ctrl_t              fb_ctrl;
  logic [AW-1:0]         fb_rd_addr, fb_wr_addr;
  logic [7:0]            fb_wr_data, fb_rd_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // timers count up and restart once they reach their period
  assign scan_inc   = scan_timer_q + TIMER_W'(1);
  assign scroll_inc = scroll_timer_q + TIMER_W'(1);
  assign scan_exp   = (scan_inc >= scan_period_q);
  assign scroll_exp = (scroll_inc >= scroll_period_q);

  assign row_next = (row_q == ROW_W'(NUM_ROWS - 1)) ? '0 : row_q + ROW_W'(1);

  // rotation span, clipped to the buffer
  assign len_eff   = (int'(scroll_length_q) > BUFFER_COLS) ? PW'(BUFFER_COLS)
                                                           : PW'(scroll_length_q);
  assign rot_ok    = (len_eff >= PW'(2));
  assign rot_next2 = PW'(rot_idx_q) + PW'(2);

  always_comb begin
    state_d        = state_q;
    scan_timer_d   = scan_timer_q;
    scroll_timer_d = scroll_timer_q;
    row_d          = row_q;
    wp_d           = wp_q;
    col_d          = col_q;
    sel_d          = sel_q;
    gcnt_d         = gcnt_q;
    rot_pend_d     = rot_pend_q;
    rot_idx_d      = rot_idx_q;
    scan_oob_d     = scan_oob_q;
    glyph_d        = glyph_q;
    first_d        = first_q;
    out_res_d      = out_res_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    fb_ctrl        = '0;
    fb_rd_addr     = '0;
    fb_wr_addr     = '0;
    fb_wr_data     = '0;
    scan_rd        = 1'b0;
    col_rd         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_i.command == CMD_CHAR) begin
            // a new message drops all columns before the glyph goes in
            fb_ctrl.clr = in_req_i.first_of_message;
            if (in_req_i.first_of_message) begin
              wp_d = '0;
            end
            glyph_d = font_glyph(in_req_i.char_code);
            gcnt_d  = '0;
            state_d = S_CHAR;
          end else begin
            scan_timer_d   = scan_exp ? '0 : scan_inc;
            scroll_timer_d = scroll_exp ? '0 : scroll_inc;
            rot_pend_d     = scroll_exp && rot_ok;
            if (scan_exp) begin
              // scan goes first, last visible column first
              row_d   = row_next;
              col_d   = CW'(VISIBLE_COLS - 1);
              scan_rd = 1'b1;
              col_rd  = CW'(VISIBLE_COLS - 1);
              state_d = S_SCAN;
            end else if (scroll_exp && rot_ok) begin
              state_d = S_ROT_HEAD;
            end
          end
        end
      end

      S_CHAR: begin
        // columns past the buffer end are dropped
        if (int'(wp_q) < BUFFER_COLS) begin
          fb_ctrl.wr_en = 1'b1;
          fb_wr_addr    = AW'(wp_q);
          fb_wr_data    = glyph_q[GLYPH_BITS-1 -: 8];
          wp_d          = wp_q + PW'(1);
        end
        glyph_d = glyph_q << 8;
        gcnt_d  = gcnt_q + GW'(1);
        if (gcnt_q == GW'(GLYPH_WIDTH - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        // read data for col_q is waiting; fetch the next column as it leaves
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_res_d.serial_bit   = scan_oob_q ? 1'b0 : fb_rd_data[row_q];
          out_res_d.latch_strobe = 1'b0;
          if (col_q == '0) begin
            sel_d   = '0;
            state_d = S_SEL;
          end else begin
            col_d   = col_q - CW'(1);
            scan_rd = 1'b1;
            col_rd  = col_q - CW'(1);
          end
        end
      end

      S_SEL: begin
        // one-hot row select, lsb first, latch on the final bit
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_res_d.serial_bit   = (row_q == sel_q);
          out_res_d.latch_strobe = (sel_q == SW'(SELECT_BITS - 1));
          if (sel_q == SW'(SELECT_BITS - 1)) begin
            state_d = rot_pend_q ? S_ROT_HEAD : S_IDLE;
          end else begin
            sel_d = sel_q + SW'(1);
          end
        end
      end

      S_ROT_HEAD: begin
        fb_ctrl.rd_en = 1'b1;
        fb_rd_addr    = '0;
        state_d       = S_ROT_FIRST;
      end

      S_ROT_FIRST: begin
        // keep column 0, it wraps to the end of the span
        first_d       = fb_rd_data;
        fb_ctrl.rd_en = 1'b1;
        fb_rd_addr    = AW'(1);
        rot_idx_d     = '0;
        state_d       = S_ROT_MOVE;
      end

      S_ROT_MOVE: begin
        // write column i from i+1 while reading i+2
        fb_ctrl.wr_en = 1'b1;
        fb_wr_addr    = rot_idx_q;
        fb_wr_data    = fb_rd_data;
        if (rot_next2 == len_eff) begin
          state_d = S_ROT_LAST;
        end else begin
          fb_ctrl.rd_en = 1'b1;
          fb_rd_addr    = AW'(rot_next2);
          rot_idx_d     = rot_idx_q + AW'(1);
        end
      end

      S_ROT_LAST: begin
        fb_ctrl.wr_en = 1'b1;
        fb_wr_addr    = AW'(len_eff - PW'(1));
        fb_wr_data    = first_q;
        rot_pend_d    = 1'b0;
        state_d       = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // visible columns beyond the buffer send a blank bit
    if (scan_rd) begin
      scan_oob_d = (int'(col_rd) >= BUFFER_COLS);
      if (!scan_oob_d) begin
        fb_ctrl.rd_en = 1'b1;
        fb_rd_addr    = AW'(col_rd);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      scan_period_q   <= SCAN_PERIOD_RST;
      scroll_period_q <= SCROLL_PERIOD_RST;
      scroll_length_q <= SCROLL_LENGTH_RST;
      scan_timer_q    <= '0;
      scroll_timer_q  <= '0;
      row_q           <= '0;
      wp_q            <= '0;
      col_q           <= '0;
      sel_q           <= '0;
      gcnt_q          <= '0;
      rot_pend_q      <= 1'b0;
      rot_idx_q       <= '0;
      scan_oob_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q        <= state_d;
      scan_timer_q   <= scan_timer_d;
      scroll_timer_q <= scroll_timer_d;
      row_q          <= row_d;
      wp_q           <= wp_d;
      col_q          <= col_d;
      sel_q          <= sel_d;
      gcnt_q         <= gcnt_d;
      rot_pend_q     <= rot_pend_d;
      rot_idx_q      <= rot_idx_d;
      scan_oob_q     <= scan_oob_d;
      out_valid_q    <= out_valid_d;
      // user sends register writes only while the sequencer is idle; not enforced
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_SCAN_PERIOD:   scan_period_q   <= cfg_wdata_i;
          CFG_SCROLL_PERIOD: scroll_period_q <= cfg_wdata_i;
          CFG_SCROLL_LENGTH: scroll_length_q <= cfg_wdata_i[LEN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    glyph_q   <= glyph_d;
    first_q   <= first_d;
    out_res_q <= out_res_d;
  end

  lmss_fbuf #(
    .DEPTH (BUFFER_COLS)
  ) u_fbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fb_ctrl),
    .rd_addr_i (fb_rd_addr),
    .wr_addr_i (fb_wr_addr),
    .wr_data_i (fb_wr_data),
    .rd_data_o (fb_rd_data)
  );

endmodule

// ===== src/lmss_checker.sv =====
module lmss_checker import lmss_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input cmd_in_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input res_out_t out_res_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // rendering a glyph keeps the input side busy
  a_char_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.command == CMD_CHAR) |=> !in_ready_o)
    else $error("request taken during glyph rendering");

  // a character request produces no result
  a_char_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_req_i.command == CMD_CHAR) && !out_valid_o
    |=> !out_valid_o)
    else $error("result after character request");

  // a row frame starts only while a scan is underway
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result started while idle");

endmodule

bind led_matrix_scan_scroll_top lmss_checker u_lmss_checker (.*);
